/* sv/ptrt_pkg.sv */
// Package with the request, result and chain types of the periodic task release table.
`default_nettype none
package ptrt_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int PERIOD_BITS_DEF = 16;
    localparam int MASK_W          = 8;
    localparam int PERIOD_FIELD_W  = 16;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_CREATE  = 3'd1,
        REQ_SUSPEND = 3'd2,
        REQ_RESUME  = 3'd3,
        REQ_DELETE  = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_IN_USE       = 2'd1,
        ST_CREATE_RANGE = 2'd2,
        ST_NO_SLOT      = 2'd3
    } status_code_t;

    typedef struct packed {
        logic [2:0]                req_type;
        logic [7:0]                slot;
        logic [PERIOD_FIELD_W-1:0] period;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [MASK_W-1:0] fire_mask;
    } rsp_t;

    typedef struct packed {
        logic [MASK_W-1:0] fire_mask;
        logic              hit_used;
    } chain_t;

endpackage
`default_nettype wire

/* sv/ptrt_cell.sv */
// One task slot cell: holds the slot state and extends the fire mask along the chain.
`default_nettype none
module ptrt_cell
    import ptrt_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire req_t                   cmd,
    input  wire logic [PERIOD_BITS-1:0] per,
    input  wire chain_t                 chain_in,
    output chain_t                      chain_out
);

    logic                   in_use_reg, in_use_next;
    logic                   susp_reg, susp_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [PERIOD_BITS-1:0] count_reg, count_next;
    logic                   hit;
    logic                   fire;

    assign hit = (cmd.slot == 8'(IDX));

    always_comb
    begin
        in_use_next = in_use_reg;
        susp_next   = susp_reg;
        period_next = period_reg;
        count_next  = count_reg;
        fire        = 1'b0;
        if (accept)
        begin
            case (cmd.req_type)
                REQ_TICK:
                begin
                    if (in_use_reg && !susp_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            fire       = 1'b1;
                            count_next = period_reg;
                        end
                        else
                        begin
                            count_next = count_reg - PERIOD_BITS'(1);
                        end
                    end
                end
                REQ_CREATE:
                begin
                    if (hit && !in_use_reg)
                    begin
                        in_use_next = 1'b1;
                        susp_next   = 1'b0;
                        period_next = per;
                        count_next  = '0;
                    end
                end
                REQ_SUSPEND:
                begin
                    if (hit && in_use_reg)
                    begin
                        susp_next = 1'b1;
                    end
                end
                REQ_RESUME:
                begin
                    if (hit)
                    begin
                        susp_next = 1'b0;
                    end
                end
                REQ_DELETE:
                begin
                    if (hit)
                    begin
                        in_use_next = 1'b0;
                        susp_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign chain_out.fire_mask = chain_in.fire_mask
                               | ({MASK_W{fire}} & (MASK_W'(1) << IDX));
    assign chain_out.hit_used  = chain_in.hit_used | (hit & in_use_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            susp_reg   <= 1'b0;
            period_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            susp_reg   <= susp_next;
            period_reg <= period_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* sv/periodic_task_release_table.sv */
// Top level of the periodic task release table: a chain of slot cells and the result register.
//
//   channel   signals              direction   transfer
//   request   start, busy, cmd     in          start high and busy low at a clock edge
//   result    done, result         out         done high for one cycle, always taken
//
// A request is accepted in any cycle; busy is always low.
// Its result appears on the cycle after acceptance, one result per request.
// All slot cells update in the cycle of acceptance; the fire mask ripples through the chain.
// Reset clears every slot to free, and the result strobe to low.
// The receiver cannot stall, so nothing waits on the output side.
`default_nettype none
module periodic_task_release_table
    import ptrt_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t cmd,
    output logic      done,
    output rsp_t      result
);

    logic                                accept;
    logic                                in_range;
    logic [PERIOD_BITS+PERIOD_FIELD_W-1:0] per_wide;
    logic [PERIOD_BITS-1:0]              per;
    chain_t                              chain [NUM_SLOTS+1];
    logic                                done_reg, done_next;
    rsp_t                                result_reg, result_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign in_range = (cmd.slot < 8'(NUM_SLOTS));
    assign per_wide = {{PERIOD_BITS{1'b0}}, cmd.period};
    assign per      = per_wide[PERIOD_BITS-1:0];

    assign chain[0] = '0;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        ptrt_cell #(
            .IDX         (i),
            .PERIOD_BITS (PERIOD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (accept),
            .cmd       (cmd),
            .per       (per),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_comb
    begin
        done_next             = accept;
        result_next.status    = ST_OK;
        result_next.fire_mask = '0;
        case (cmd.req_type)
            REQ_TICK:
            begin
                result_next.fire_mask = chain[NUM_SLOTS].fire_mask;
            end
            REQ_CREATE:
            begin
                if (!in_range)
                begin
                    result_next.status = ST_CREATE_RANGE;
                end
                else if (chain[NUM_SLOTS].hit_used)
                begin
                    result_next.status = ST_IN_USE;
                end
            end
            REQ_SUSPEND, REQ_RESUME, REQ_DELETE:
            begin
                if (!in_range)
                begin
                    result_next.status = ST_NO_SLOT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result strobe without an accepted request");

    a_fire_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fire_mask != '0) |-> $past(cmd.req_type == REQ_TICK))
        else $error("fire mask set for a request other than tick");

    a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_CREATE_RANGE || result.status == ST_NO_SLOT))
        |-> $past(cmd.slot >= 8'(NUM_SLOTS)))
        else $error("range status for an in-range slot");
`endif

endmodule
`default_nettype wire
